@@ rtl/core/rpn_stack_evaluator_defines.svh @@
// Assertion macros for the RPN stack evaluator.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef RPN_STACK_EVALUATOR_DEFINES_SVH
`define RPN_STACK_EVALUATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RPN_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RPN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/rpn_pkg.sv @@
// Shared types and constants for the RPN stack evaluator.
// Used by rpn_alu and rpn_stack_evaluator; no dependencies.
package rpn_pkg;

    localparam int DATA_W          = 32;
    localparam int DIGIT_W         = 5;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int CNT_W           = $clog2(DATA_W);
    localparam int S_TDATA_W       = 8;
    localparam int M_TDATA_W       = 40;

    localparam logic signed [DIGIT_W-1:0] DIGIT_MAX = 5'sd9;
    localparam logic signed [DIGIT_W-1:0] DIGIT_MIN = -5'sd9;

    typedef enum logic [1:0] {
        KIND_NUM = 2'd0,
        KIND_OP  = 2'd1,
        KIND_END = 2'd2,
        KIND_BAD = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_FEW      = 3'd2,
        ST_DIVZERO  = 3'd3,
        ST_LEFTOVER = 3'd4,
        ST_EMPTY    = 3'd5,
        ST_OVERFLOW = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        A_IDLE,
        A_ONE,
        A_MUL,
        A_ABSA,
        A_ABSB,
        A_DIV,
        A_FIX
    } alu_state_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_A,
        S_GO,
        S_WAIT,
        S_OUT
    } seq_state_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic dz;
    } alu_rsp_t;

endpackage

@@ rtl/core/rpn_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/rpn_alu.sv @@
// Iterative arithmetic unit: one shared 34-bit adder drives add, subtract,
// shift-add multiply and restoring divide. Depends on rpn_pkg.
module rpn_alu
    import rpn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  alu_req_t          req,
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    output alu_rsp_t          rsp,
    output logic [DATA_W-1:0] result
);

    alu_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic              dz_reg, dz_next;
    op_t               op_reg, op_next;
    logic              neg_reg, neg_next;
    logic [DATA_W-1:0] x_reg, x_next;
    logic [DATA_W-1:0] y_reg, y_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [DATA_W-1:0] result_reg, result_next;

    logic [DATA_W+1:0] add_x, add_y, add_sum;
    logic              add_sub;
    logic [DATA_W:0]   shifted;
    logic              last;

    assign last    = cnt_reg == CNT_W'(DATA_W - 1);
    assign shifted = {acc_reg, x_reg[DATA_W-1]};
    assign add_sum = add_x + (add_sub ? ~add_y : add_y) + {{(DATA_W+1){1'b0}}, add_sub};

    always_comb
    begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        unique case (state_reg)
            A_ONE:
            begin
                add_x   = {2'b00, x_reg};
                add_y   = {2'b00, y_reg};
                add_sub = op_reg == OP_SUB;
            end
            A_MUL:
            begin
                add_x = {2'b00, acc_reg};
                add_y = {2'b00, y_reg};
            end
            A_ABSA, A_FIX:
            begin
                add_y   = {2'b00, x_reg};
                add_sub = 1'b1;
            end
            A_ABSB:
            begin
                add_y   = {2'b00, y_reg};
                add_sub = 1'b1;
            end
            A_DIV:
            begin
                add_x   = {1'b0, shifted};
                add_y   = {2'b00, y_reg};
                add_sub = 1'b1;
            end
            default:
            begin
                add_x = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    unique case (req.op)
                        OP_ADD, OP_SUB: state_next = A_ONE;
                        OP_MUL:         state_next = A_MUL;
                        OP_DIV:         state_next = (b == '0) ? A_IDLE : A_ABSA;
                        default:        state_next = A_IDLE;
                    endcase
                end
            end
            A_ONE:   state_next = A_IDLE;
            A_MUL:   state_next = last ? A_IDLE : A_MUL;
            A_ABSA:  state_next = A_ABSB;
            A_ABSB:  state_next = A_DIV;
            A_DIV:   state_next = last ? A_FIX : A_DIV;
            A_FIX:   state_next = A_IDLE;
            default: state_next = A_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        dz_next     = 1'b0;
        op_next     = op_reg;
        neg_next    = neg_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        acc_next    = acc_reg;
        result_next = result_reg;
        unique case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    op_next  = req.op;
                    x_next   = a;
                    y_next   = b;
                    neg_next = a[DATA_W-1] ^ b[DATA_W-1];
                    acc_next = '0;
                    cnt_next = '0;
                    if (req.op == OP_DIV && b == '0)
                    begin
                        done_next = 1'b1;
                        dz_next   = 1'b1;
                    end
                end
            end
            A_ONE:
            begin
                result_next = add_sum[DATA_W-1:0];
                done_next   = 1'b1;
            end
            A_MUL:
            begin
                if (x_reg[0])
                begin
                    acc_next = add_sum[DATA_W-1:0];
                end
                x_next   = {1'b0, x_reg[DATA_W-1:1]};
                y_next   = {y_reg[DATA_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (last)
                begin
                    result_next = x_reg[0] ? add_sum[DATA_W-1:0] : acc_reg;
                    done_next   = 1'b1;
                end
            end
            A_ABSA:
            begin
                x_next = x_reg[DATA_W-1] ? add_sum[DATA_W-1:0] : x_reg;
            end
            A_ABSB:
            begin
                y_next   = y_reg[DATA_W-1] ? add_sum[DATA_W-1:0] : y_reg;
                acc_next = '0;
                cnt_next = '0;
            end
            A_DIV:
            begin
                acc_next = add_sum[DATA_W+1] ? shifted[DATA_W-1:0] : add_sum[DATA_W-1:0];
                x_next   = {x_reg[DATA_W-2:0], ~add_sum[DATA_W+1]};
                cnt_next = cnt_reg + 1'b1;
            end
            A_FIX:
            begin
                result_next = neg_reg ? add_sum[DATA_W-1:0] : x_reg;
                done_next   = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            dz_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            dz_reg    <= dz_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        neg_reg    <= neg_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
    end

    assign rsp.done = done_reg;
    assign rsp.dz   = dz_reg;
    assign result   = result_reg;

endmodule

@@ rtl/core/rpn_stack_evaluator.sv @@
// RPN stack evaluator top level: token sequencer, stack pointer, error latch
// and result register. Depends on rpn_pkg, rpn_ram, rpn_alu and the defines header.
//
// Usage:
//   Input beats carry one classified token: s_tuser is the kind (number,
//   operator, end, invalid), s_tdata holds the digit and the operator.
//   Only end tokens produce an output beat on m_tdata (value, status).
//   Work per token before the next beat is taken:
//     number, invalid, too few operands, or any token under an error: idle state
//     add / subtract: two stack reads, then one ALU add; divide by zero: ALU stops at start
//     multiply: one shift-add step per cycle
//     divide: one quotient bit per cycle plus sign fix
//     end: the result is placed in the output register
//   The shared iterative ALU and the single read port of the stack RAM
//   (both operands read one after the other) set this work.
//   One token is in flight at a time; s_tready is low while it works.
//   A result waits in the output register while the next tokens are taken;
//   a stalled m_tready holds the following end token until the beat drains.
//   Reset empties the stack and clears the error; the stack RAM is not
//   cleared, entries above the stack pointer are never used.
`include "rpn_stack_evaluator_defines.svh"

module rpn_stack_evaluator
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // digit[4:0], op[6:5], zero[7]
    input  logic [1:0]           s_tuser,  // kind[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // value[31:0], status[34:32], zero[39:35]
);

    localparam int ADDR_W  = $clog2(STACK_DEPTH);
    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(STACK_DEPTH);
    localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);
    localparam logic [DEPTH_W-1:0] DEPTH_TWO = DEPTH_W'(2);

    seq_state_t          state_reg, state_next;
    logic [DEPTH_W-1:0]  depth_reg, depth_next;
    status_t             err_reg, err_next;
    op_t                 op_reg, op_next;
    logic [DATA_W-1:0]   b_reg, b_next;
    logic                res_ram_reg, res_ram_next;
    status_t             res_status_reg, res_status_next;
    logic                out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]   out_value_reg, out_value_next;
    status_t             out_status_reg, out_status_next;

    kind_t                     in_kind;
    logic signed [DIGIT_W-1:0] in_digit;
    op_t                       in_op;
    logic                      accept;
    logic                      digit_bad;
    logic                      op_go;
    logic                      out_free;
    logic [DEPTH_W-1:0]        depth_m1, depth_m2;

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_wdata, ram_rdata;

    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;
    logic [DATA_W-1:0] alu_result;

    assign in_kind   = kind_t'(s_tuser);
    assign in_digit  = s_tdata[DIGIT_W-1:0];
    assign in_op     = op_t'(s_tdata[DIGIT_W+1:DIGIT_W]);
    assign accept    = s_tvalid && s_tready;
    assign digit_bad = (in_digit > DIGIT_MAX) || (in_digit < DIGIT_MIN);
    assign op_go     = in_kind == KIND_OP && err_reg == ST_OK && depth_reg >= DEPTH_TWO;
    assign out_free  = !out_valid_reg || m_tready;
    assign depth_m1  = depth_reg - DEPTH_ONE;
    assign depth_m2  = depth_reg - DEPTH_TWO;

    rpn_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rpn_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (ram_rdata),
        .b      (b_reg),
        .rsp    (alu_rsp),
        .result (alu_result)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && in_kind == KIND_END)
                begin
                    state_next = S_OUT;
                end
                else if (accept && op_go)
                begin
                    state_next = S_RD_A;
                end
            end
            S_RD_A:  state_next = S_GO;
            S_GO:    state_next = S_WAIT;
            S_WAIT:  state_next = alu_rsp.done ? S_IDLE : S_WAIT;
            S_OUT:   state_next = out_free ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready        = state_reg == S_IDLE;
        ram_we          = 1'b0;
        ram_waddr       = depth_reg[ADDR_W-1:0];
        ram_wdata       = {{(DATA_W-DIGIT_W){in_digit[DIGIT_W-1]}}, in_digit};
        ram_re          = 1'b0;
        ram_raddr       = depth_m1[ADDR_W-1:0];
        alu_req.start   = 1'b0;
        alu_req.op      = op_reg;
        depth_next      = depth_reg;
        err_next        = err_reg;
        op_next         = op_reg;
        b_next          = b_reg;
        res_ram_next    = res_ram_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_kind == KIND_END)
                    begin
                        ram_re       = 1'b1;
                        ram_raddr    = '0;
                        res_ram_next = err_reg == ST_OK && depth_reg == DEPTH_ONE;
                        if (err_reg != ST_OK)
                        begin
                            res_status_next = err_reg;
                        end
                        else if (depth_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else if (depth_reg > DEPTH_ONE)
                        begin
                            res_status_next = ST_LEFTOVER;
                        end
                        else
                        begin
                            res_status_next = ST_OK;
                        end
                        depth_next = '0;
                        err_next   = ST_OK;
                    end
                    else if (err_reg == ST_OK)
                    begin
                        unique case (in_kind)
                            KIND_BAD:
                            begin
                                err_next = ST_INVALID;
                            end
                            KIND_NUM:
                            begin
                                if (digit_bad)
                                begin
                                    err_next = ST_INVALID;
                                end
                                else if (depth_reg == DEPTH_MAX)
                                begin
                                    err_next = ST_OVERFLOW;
                                end
                                else
                                begin
                                    ram_we     = 1'b1;
                                    depth_next = depth_reg + DEPTH_ONE;
                                end
                            end
                            KIND_OP:
                            begin
                                if (op_go)
                                begin
                                    ram_re  = 1'b1;
                                    op_next = in_op;
                                end
                                else
                                begin
                                    err_next = ST_FEW;
                                end
                            end
                            default:
                            begin
                                err_next = err_reg;
                            end
                        endcase
                    end
                end
            end
            S_RD_A:
            begin
                s_tready  = 1'b0;
                ram_re    = 1'b1;
                ram_raddr = depth_m2[ADDR_W-1:0];
                b_next    = ram_rdata;
            end
            S_GO:
            begin
                alu_req.start = 1'b1;
            end
            S_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    if (alu_rsp.dz)
                    begin
                        err_next = ST_DIVZERO;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = depth_m2[ADDR_W-1:0];
                        ram_wdata  = alu_result;
                        depth_next = depth_m1;
                    end
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_ram_reg ? ram_rdata : '0;
                    out_status_next = res_status_reg;
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        b_reg          <= b_next;
        res_ram_reg    <= res_ram_next;
        res_status_reg <= res_status_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-DATA_W-3){1'b0}}, out_status_reg, out_value_reg};

    `RPN_ASSERT_SAME(a_depth_bound, 1'b1, depth_reg <= DEPTH_MAX,
        "stack pointer beyond stack depth")
    `RPN_ASSERT_NEXT(a_end_clears, accept && in_kind == KIND_END,
        depth_reg == '0 && err_reg == ST_OK, "end token did not clear the stack")
    `RPN_ASSERT_NEXT(a_err_holds, accept && in_kind != KIND_END && err_reg != ST_OK,
        $stable(depth_reg) && $stable(err_reg), "token changed state under a latched error")
    `RPN_ASSERT_NEXT(a_alu_return, state_reg == S_WAIT && alu_rsp.done,
        state_reg == S_IDLE, "sequencer did not return to idle after the ALU finished")

endmodule

@@ test/tb_rpn_stack_evaluator.sv @@
// Testbench for rpn_stack_evaluator: drives classified tokens, predicts each end-of-expression
// result in a local stack calculator and checks every output beat field by field.
// Depends on rpn_pkg and the RTL of rpn_stack_evaluator.
module tb_rpn_stack_evaluator;
    import rpn_pkg::*;

    localparam int STK_DEPTH    = STACK_DEPTH_DEF;
    localparam int TOKEN_COUNT  = 1200;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 100;

    typedef struct {
        kind_t      kind;
        logic [4:0] digit;
        op_t        op;
        bit         hold;
    } token_t;

    typedef struct {
        logic [31:0] value;
        status_t     status;
    } eval_result_t;

    logic                 clk;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;  // digit[4:0], op[6:5], zero[7]
    logic [1:0]           s_tuser  = KIND_NUM;  // kind[1:0]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;  // value[31:0], status[34:32], zero[39:35]

    token_t       token_q[$];
    eval_result_t eval_result_q[$];

    logic [31:0] calc_stack[STK_DEPTH];
    int          calc_depth = 0;
    status_t     calc_err   = ST_OK;

    int mismatch_count = 0;
    int idle_cycles    = 0;
    int gap_left       = 0;
    int stall_left     = 0;
    int beats_in       = 0;
    int beats_out      = 0;
    bit calm_in        = 1'b0;
    bit calm_out       = 1'b0;
    bit hold_next      = 1'b0;

    rpn_stack_evaluator #(
        .STACK_DEPTH(STK_DEPTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void eval_token(kind_t kind, logic [4:0] digit, op_t op);
        logic signed [31:0] lhs;
        logic signed [31:0] rhs;
        logic signed [31:0] res;
        eval_result_t       outcome;
        if (kind == KIND_END)
        begin
            outcome.value = '0;
            if (calc_err != ST_OK)
                outcome.status = calc_err;
            else if (calc_depth == 0)
                outcome.status = ST_EMPTY;
            else if (calc_depth > 1)
                outcome.status = ST_LEFTOVER;
            else
            begin
                outcome.status = ST_OK;
                outcome.value  = calc_stack[0];
            end
            eval_result_q.push_back(outcome);
            calc_depth = 0;
            calc_err   = ST_OK;
        end
        else if (calc_err != ST_OK)
        begin
            // drop: error already latched
        end
        else if (kind == KIND_BAD)
            calc_err = ST_INVALID;
        else if (kind == KIND_NUM)
        begin
            if ($signed(digit) > DIGIT_MAX || $signed(digit) < DIGIT_MIN)
                calc_err = ST_INVALID;
            else if (calc_depth >= STK_DEPTH)
                calc_err = ST_OVERFLOW;
            else
            begin
                calc_stack[calc_depth] = {{27{digit[4]}}, digit};
                calc_depth++;
            end
        end
        else if (calc_depth < 2)
            calc_err = ST_FEW;
        else
        begin
            rhs = calc_stack[calc_depth - 1];
            lhs = calc_stack[calc_depth - 2];
            res = '0;
            case (op)
                OP_ADD: res = lhs + rhs;
                OP_SUB: res = lhs - rhs;
                OP_MUL: res = lhs * rhs;
                OP_DIV:
                begin
                    if (rhs == 0)
                        calc_err = ST_DIVZERO;
                    else if (lhs == 32'sh8000_0000 && rhs == -32'sd1)
                        res = lhs;
                    else
                        res = lhs / rhs;
                end
            endcase
            if (calc_err == ST_OK)
            begin
                calc_depth--;
                calc_stack[calc_depth - 1] = res;
            end
        end
    endfunction

    function automatic int next_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR %s: got 0x%08h, expected 0x%08h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic add_token(kind_t kind, logic [4:0] digit, op_t op);
        token_t tok;
        tok.kind  = kind;
        tok.digit = digit;
        tok.op    = op;
        tok.hold  = hold_next;
        hold_next = 1'b0;
        token_q.push_back(tok);
    endtask

    task automatic add_num(int v);
        add_token(KIND_NUM, v[4:0], op_t'($urandom_range(0, 3)));
    endtask

    task automatic add_op(op_t op);
        add_token(KIND_OP, 5'($urandom), op);
    endtask

    task automatic add_end();
        add_token(KIND_END, 5'($urandom), op_t'($urandom_range(0, 3)));
    endtask

    function automatic op_t rand_op();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return OP_MUL;
        if (r < 6)
            return OP_DIV;
        if (r < 8)
            return OP_ADD;
        return OP_SUB;
    endfunction

    task automatic rand_expr(int n_nums);
        int depth;
        int nums;
        depth = 0;
        nums  = 0;
        while (!(nums == n_nums && depth == 1))
        begin
            if (depth < 2 || (nums < n_nums && $urandom_range(0, 1) == 1))
            begin
                add_num($urandom_range(0, 18) - 9);
                nums++;
                depth++;
            end
            else
            begin
                add_op(rand_op());
                depth--;
            end
        end
    endtask

    function automatic int expr_size();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(9, 40);
        return $urandom_range(1, 8);
    endfunction

    task automatic deep_stack(bit spill);
        repeat (STK_DEPTH) add_num($urandom_range(0, 18) - 9);
        if (spill)
            add_num($urandom_range(0, 18) - 9);
        else
            repeat (STK_DEPTH - 1) add_op(op_t'($urandom_range(0, 3)));
        add_end();
    endtask

    // build the most negative value as -2 * 2^30, then apply op with -1
    task automatic min_value_op(op_t op);
        add_num(-2);
        repeat (30)
        begin
            add_num(2);
            add_op(OP_MUL);
        end
        add_num(-1);
        add_op(op);
        add_end();
    endtask

    task automatic build_tokens();
        int r;
        int seqs;
        add_end();
        add_num(9);
        add_num(-9);
        add_op(OP_ADD);
        add_end();
        add_num(7);
        add_num(-3);
        add_op(OP_MUL);
        add_num(2);
        add_op(OP_SUB);
        add_num(4);
        add_op(OP_DIV);
        add_end();
        add_num(5);
        add_num(0);
        add_op(OP_DIV);
        add_end();
        add_num(5);
        add_op(OP_ADD);
        add_end();
        add_token(KIND_BAD, 5'd0, OP_ADD);
        add_num(4);
        add_end();
        add_token(KIND_NUM, 5'd10, OP_SUB);
        add_end();
        add_num(1);
        add_num(2);
        add_end();

        hold_next = 1'b1;
        min_value_op(OP_DIV);
        deep_stack(1'b1);
        deep_stack(1'b0);
        seqs = 0;
        while (token_q.size() < TOKEN_COUNT)
        begin
            seqs++;
            if (seqs % 25 == 0)
                hold_next = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 60)
                rand_expr(expr_size());
            else if (r < 75)
            begin
                repeat ($urandom_range(1, 8))
                    add_token(kind_t'($urandom_range(0, 3)), 5'($urandom),
                              op_t'($urandom_range(0, 3)));
            end
            else if (r < 90)
            begin
                rand_expr(expr_size());
                case ($urandom_range(0, 3))
                    0: add_op(op_t'($urandom_range(0, 3)));
                    1: add_num($urandom_range(0, 18) - 9);
                    2: add_token(KIND_BAD, 5'($urandom), op_t'($urandom_range(0, 3)));
                    default: add_token(KIND_NUM, 5'($urandom_range(10, 22)), OP_ADD);
                endcase
            end
            else if (r < 95)
            begin
                rand_expr(expr_size());
                add_num(0);
                add_op(OP_DIV);
            end
            else if (r < 98)
            begin
                min_value_op(op_t'($urandom_range(0, 3)));
                continue;
            end
            else
            begin
                deep_stack($urandom_range(0, 1));
                continue;
            end
            add_end();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        token_t tok;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= KIND_NUM;
            gap_left = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                eval_token(kind_t'(s_tuser), s_tdata[4:0], op_t'(s_tdata[6:5]));
                beats_in++;
                if (beats_in % 64 == 0)
                    calm_in = ($urandom_range(0, 3) == 0);
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (token_q.size() != 0
                         && !(token_q[0].hold && eval_result_q.size() != 0))
                begin
                    tok = token_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {1'b0, tok.op, tok.digit};
                    s_tuser  <= tok.kind;
                    gap_left = next_gap(calm_in);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        eval_result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (eval_result_q.size() == 0)
                    report_mismatch("result with none expected", m_tdata[31:0], '0);
                else
                begin
                    want = eval_result_q.pop_front();
                    if (m_tdata[31:0] !== want.value)
                        report_mismatch("value", m_tdata[31:0], want.value);
                    if (m_tdata[34:32] !== want.status)
                        report_mismatch("status", 32'(m_tdata[34:32]), 32'(want.status));
                end
                beats_out++;
                if (beats_out % 16 == 0)
                    calm_out = ($urandom_range(0, 3) == 0);
                stall_left = next_gap(calm_out);
            end
            else if (!m_tvalid && $urandom_range(0, 7) == 0)
                stall_left = next_gap(calm_out);
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        build_tokens();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        while (token_q.size() != 0 || s_tvalid)
            @(posedge clk);
        while (eval_result_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && eval_result_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
